// ===== sv/pqm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pqm_pkg;

    localparam int TAPS    = 33;
    localparam int TAP_W   = 6;
    localparam int SYM_W   = 12;
    localparam int COEF_W  = 18;
    localparam int ACC_W   = 30;
    localparam int DAC_W   = 12;

    // dac code = sum >>> 15, so the 12 bits above bit 14 of the sum
    localparam int DAC_LSB = 15;

    localparam logic [DAC_W-1:0] DAC_OFFSET = 12'd2125;

    localparam logic signed [SYM_W-1:0] SYM_GAIN  = 12'sd1960;
    localparam logic signed [SYM_W-1:0] SYM_THIRD = 12'sd653;
    localparam logic signed [SYM_W-1:0] SYM_DIAG  = 12'sd1385;

    typedef logic signed [SYM_W-1:0]  t_sym;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // modulation codes
    localparam logic [1:0] MOD_BPSK  = 2'd0;
    localparam logic [1:0] MOD_QPSK  = 2'd1;
    localparam logic [1:0] MOD_8PSK  = 2'd2;
    localparam logic [1:0] MOD_QAM16 = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MODULATION = 2'd0;
    localparam logic [1:0] CFG_FILTER_EN  = 2'd1;
    localparam logic [1:0] CFG_SPS        = 2'd2;
    localparam logic [1:0] CFG_BUF_LEN    = 2'd3;

    // request kinds
    localparam logic KIND_BYTE_WR = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    function automatic t_coef rrc_coef(input logic [TAP_W-1:0] k);
        t_coef c;
        unique case (k)
            6'd0,  6'd32: c = 18'sd694;
            6'd1,  6'd31: c = 18'sd380;
            6'd2,  6'd30: c = -18'sd635;
            6'd3,  6'd29: c = -18'sd1402;
            6'd4,  6'd28: c = -18'sd1232;
            6'd5,  6'd27: c = 18'sd196;
            6'd6,  6'd26: c = 18'sd2143;
            6'd7,  6'd25: c = 18'sd3086;
            6'd8,  6'd24: c = 18'sd1736;
            6'd9,  6'd23: c = -18'sd1802;
            6'd10, 6'd22: c = -18'sd5583;
            6'd11, 6'd21: c = -18'sd6514;
            6'd12, 6'd20: c = -18'sd2103;
            6'd13, 6'd19: c = 18'sd7798;
            6'd14, 6'd18: c = 18'sd20381;
            6'd15, 6'd17: c = 18'sd30913;
            6'd16:        c = 18'sd35015;
            default:      c = '0;
        endcase
        return c;
    endfunction

    function automatic t_sym psk8_i(input logic [2:0] b);
        t_sym s;
        unique case (b)
            3'd0:    s = SYM_GAIN;
            3'd1:    s = SYM_DIAG;
            3'd2:    s = '0;
            3'd3:    s = -SYM_DIAG;
            3'd4:    s = -SYM_GAIN;
            3'd5:    s = -SYM_DIAG;
            3'd6:    s = '0;
            default: s = SYM_DIAG;
        endcase
        return s;
    endfunction

    function automatic t_sym psk8_q(input logic [2:0] b);
        t_sym s;
        unique case (b)
            3'd0:    s = '0;
            3'd1:    s = SYM_DIAG;
            3'd2:    s = SYM_GAIN;
            3'd3:    s = SYM_DIAG;
            3'd4:    s = '0;
            3'd5:    s = -SYM_DIAG;
            3'd6:    s = -SYM_GAIN;
            default: s = -SYM_DIAG;
        endcase
        return s;
    endfunction

    function automatic t_sym qam_lvl(input logic [1:0] b);
        t_sym s;
        unique case (b)
            2'd0:    s = SYM_GAIN;
            2'd1:    s = SYM_THIRD;
            2'd2:    s = -SYM_THIRD;
            default: s = -SYM_GAIN;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pqm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/psk_qam_modulator_rrc.sv =====
`timescale 1ns / 1ps
`default_nettype none

// I/Q baseband modulator. A request with tuser 0 writes one byte of the transmit
// buffer; a request with tuser 1 is a sample tick and yields one pair of 12-bit
// DAC codes. Bits are taken LSB first and mapped as BPSK, QPSK, 8-PSK or 16-QAM.
// Unfiltered ticks read a new symbol from the buffer RAM only when the hold count
// is zero. Filtered ticks run a 33-tap RRC FIR through one multiply-accumulate
// pair (I and Q) stepping one tap a cycle. The result sits in an output register,
// so the next request is taken while it waits. Buffer bytes are undefined until
// written.
module psk_qam_modulator_rrc #(
    parameter int BUF_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] byte_index, [15:8] byte_value
    input  wire logic        s_axis_tuser,   // [0] kind
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // [11:0] dac_i, [23:12] dac_q
    // register writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data
);

    localparam int AW  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int RPW = $clog2(BUF_DEPTH + 1);
    localparam int CW  = (RPW > 9) ? RPW : 9;
    localparam int MW  = 20;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WR    = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_MAP   = 3'd3;
    localparam logic [2:0] S_MAC   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam int TAPS = pqm_pkg::TAPS;
    localparam int TW   = pqm_pkg::TAP_W;
    localparam int DW   = pqm_pkg::DAC_W;

    logic [2:0]           r_state;
    logic [1:0]           r_modulation;
    logic                 r_filter;
    logic [9:0]           r_sps;
    logic [8:0]           r_blen;
    logic [RPW-1:0]       r_read_pos;
    logic [2:0]           r_bit_pos;
    logic [1:0]           r_phase;
    logic [9:0]           r_hold;
    logic [DW-1:0]        r_held_i;
    logic [DW-1:0]        r_held_q;
    pqm_pkg::t_sym        r_line_i [TAPS];
    pqm_pkg::t_sym        r_line_q [TAPS];
    logic [TW-1:0]        r_tap;
    pqm_pkg::t_acc        r_prod_i;
    pqm_pkg::t_acc        r_prod_q;
    pqm_pkg::t_acc        r_acc_i;
    pqm_pkg::t_acc        r_acc_q;
    logic [7:0]           r_idx;
    logic [7:0]           r_val;
    logic                 r_out_valid;
    logic [23:0]          r_out_data;

    logic                 w_in_req;
    logic                 w_cfg_req;
    logic                 w_out_free;
    logic [CW-1:0]        w_len;
    logic [RPW-1:0]       w_rd_pos;
    logic [MW-1:0]        w_mod_r;
    logic [7:0]           w_rdata;
    logic [3:0]           w_bits;
    logic [3:0]           w_step;
    logic [3:0]           w_bit_sum;
    pqm_pkg::t_sym        w_si;
    pqm_pkg::t_sym        w_sq;
    logic [2:0]           n_bit_pos;
    logic [RPW-1:0]       n_read_pos;
    logic [10:0]          n_hold_inc;
    logic [9:0]           w_sps_eff;
    logic [9:0]           n_hold;
    pqm_pkg::t_coef       w_coef;
    pqm_pkg::t_acc        w_mul_i;
    pqm_pkg::t_acc        w_mul_q;
    logic [DW-1:0]        w_fir_i;
    logic [DW-1:0]        w_fir_q;

    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign w_in_req      = s_axis_tvalid && s_axis_tready;
    assign w_cfg_req     = i_cfg_valid && o_cfg_ready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // effective buffer length and wrapped read pointer
    always_comb begin
        if (r_blen == '0) begin
            w_len = CW'(1);
        end else if (CW'(r_blen) > CW'(BUF_DEPTH)) begin
            w_len = CW'(BUF_DEPTH);
        end else begin
            w_len = CW'(r_blen);
        end
        w_rd_pos = (CW'(r_read_pos) >= w_len) ? '0 : r_read_pos;
    end

    // byte address modulo the buffer depth, restoring style
    always_comb begin
        w_mod_r = MW'(r_idx);
        for (int k = 7; k >= 0; k--) begin
            if (w_mod_r >= (MW'(BUF_DEPTH) << k)) begin
                w_mod_r = w_mod_r - (MW'(BUF_DEPTH) << k);
            end
        end
    end

    pqm_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR),
        .i_waddr (w_mod_r[AW-1:0]),
        .i_wdata (r_val),
        .i_raddr (w_rd_pos[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // symbol mapping and bit pointer advance
    always_comb begin
        unique case (r_modulation)
            pqm_pkg::MOD_BPSK: w_step = 4'd1;
            pqm_pkg::MOD_QPSK: w_step = 4'd2;
            pqm_pkg::MOD_8PSK: w_step = 4'd3;
            default:           w_step = 4'd4;
        endcase
        w_bits = 4'(w_rdata >> r_bit_pos) & 4'((5'd1 << w_step) - 5'd1);
        unique case (r_modulation)
            pqm_pkg::MOD_BPSK: begin
                w_si = w_bits[0] ? pqm_pkg::SYM_GAIN : -pqm_pkg::SYM_GAIN;
                w_sq = '0;
            end
            pqm_pkg::MOD_QPSK: begin
                w_si = w_bits[1] ? -pqm_pkg::SYM_GAIN : pqm_pkg::SYM_GAIN;
                w_sq = w_bits[0] ? -pqm_pkg::SYM_GAIN : pqm_pkg::SYM_GAIN;
            end
            pqm_pkg::MOD_8PSK: begin
                w_si = pqm_pkg::psk8_i(w_bits[2:0]);
                w_sq = pqm_pkg::psk8_q(w_bits[2:0]);
            end
            default: begin
                w_si = pqm_pkg::qam_lvl(w_bits[3:2]);
                w_sq = pqm_pkg::qam_lvl(w_bits[1:0]);
            end
        endcase
        w_bit_sum = {1'b0, r_bit_pos} + w_step;
        if (w_bit_sum[3]) begin
            // 8-PSK carries its overflow into the next byte, the rest restart at bit 0
            n_bit_pos  = (r_modulation == pqm_pkg::MOD_8PSK) ? w_bit_sum[2:0] : 3'd0;
            n_read_pos = r_read_pos + RPW'(1);
        end else begin
            n_bit_pos  = w_bit_sum[2:0];
            n_read_pos = r_read_pos;
        end
    end

    always_comb begin
        w_sps_eff  = (r_sps == '0) ? 10'd1 : r_sps;
        n_hold_inc = 11'(r_hold) + 11'd1;
        n_hold     = (n_hold_inc >= 11'(w_sps_eff)) ? '0 : n_hold_inc[9:0];
    end

    // shared MAC: the tap at the head of each rotating line meets its coefficient
    assign w_coef  = pqm_pkg::rrc_coef(r_tap);
    assign w_mul_i = pqm_pkg::ACC_W'(r_line_i[0]) * pqm_pkg::ACC_W'(w_coef);
    assign w_mul_q = pqm_pkg::ACC_W'(r_line_q[0]) * pqm_pkg::ACC_W'(w_coef);

    assign w_fir_i = r_acc_i[pqm_pkg::DAC_LSB +: DW] + pqm_pkg::DAC_OFFSET;
    assign w_fir_q = r_acc_q[pqm_pkg::DAC_LSB +: DW] + pqm_pkg::DAC_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_modulation <= pqm_pkg::MOD_BPSK;
            r_filter     <= 1'b0;
            r_sps        <= 10'd100;
            r_blen       <= 9'd1;
            r_read_pos   <= '0;
            r_bit_pos    <= '0;
            r_phase      <= '0;
            r_hold       <= '0;
            r_held_i     <= '0;
            r_held_q     <= '0;
            r_tap        <= '0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < TAPS; k++) begin
                r_line_i[k] <= '0;
                r_line_q[k] <= '0;
            end
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_cfg_req) begin
                        unique case (i_cfg_index)
                            pqm_pkg::CFG_MODULATION: r_modulation <= i_cfg_data[1:0];
                            pqm_pkg::CFG_FILTER_EN:  r_filter     <= i_cfg_data[0];
                            pqm_pkg::CFG_SPS: begin
                                r_sps  <= i_cfg_data;
                                r_hold <= '0;
                            end
                            pqm_pkg::CFG_BUF_LEN: begin
                                r_blen     <= i_cfg_data[8:0];
                                r_read_pos <= '0;
                                r_bit_pos  <= '0;
                            end
                        endcase
                    end else if (w_in_req) begin
                        if (s_axis_tuser == pqm_pkg::KIND_BYTE_WR) begin
                            r_state <= S_WR;
                        end else if (r_filter) begin
                            r_phase <= r_phase + 2'd1;
                            if (r_phase == '0) begin
                                r_state <= S_FETCH;
                            end else begin
                                // zero stuffing between symbols
                                for (int k = TAPS - 1; k > 0; k--) begin
                                    r_line_i[k] <= r_line_i[k-1];
                                    r_line_q[k] <= r_line_q[k-1];
                                end
                                r_line_i[0] <= '0;
                                r_line_q[0] <= '0;
                                r_tap       <= '0;
                                r_state     <= S_MAC;
                            end
                        end else begin
                            r_hold  <= n_hold;
                            r_state <= (r_hold == '0) ? S_FETCH : S_DONE;
                        end
                    end
                end
                S_WR: begin
                    r_state <= S_IDLE;
                end
                S_FETCH: begin
                    r_read_pos <= w_rd_pos;
                    r_state    <= S_MAP;
                end
                S_MAP: begin
                    r_bit_pos  <= n_bit_pos;
                    r_read_pos <= n_read_pos;
                    if (r_filter) begin
                        for (int k = TAPS - 1; k > 0; k--) begin
                            r_line_i[k] <= r_line_i[k-1];
                            r_line_q[k] <= r_line_q[k-1];
                        end
                        r_line_i[0] <= w_si;
                        r_line_q[0] <= w_sq;
                        r_tap       <= '0;
                        r_state     <= S_MAC;
                    end else begin
                        r_held_i <= DW'(w_si) + pqm_pkg::DAC_OFFSET;
                        r_held_q <= DW'(w_sq) + pqm_pkg::DAC_OFFSET;
                        r_state  <= S_DONE;
                    end
                end
                S_MAC: begin
                    // full turn over all taps leaves the line where it started
                    for (int k = 0; k < TAPS - 1; k++) begin
                        r_line_i[k] <= r_line_i[k+1];
                        r_line_q[k] <= r_line_q[k+1];
                    end
                    r_line_i[TAPS-1] <= r_line_i[0];
                    r_line_q[TAPS-1] <= r_line_q[0];
                    r_tap            <= r_tap + TW'(1);
                    if (r_tap == TW'(TAPS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_req) begin
            r_idx    <= s_axis_tdata[7:0];
            r_val    <= s_axis_tdata[15:8];
            r_prod_i <= '0;
            r_prod_q <= '0;
            r_acc_i  <= '0;
            r_acc_q  <= '0;
        end
        if (r_state == S_MAC) begin
            r_prod_i <= w_mul_i;
            r_prod_q <= w_mul_q;
        end
        if (r_state == S_MAC || r_state == S_DRAIN) begin
            r_acc_i <= r_acc_i + r_prod_i;
            r_acc_q <= r_acc_q + r_prod_q;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= r_filter ? {w_fir_q, w_fir_i} : {r_held_q, r_held_i};
        end
    end

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_tap < TW'(TAPS)))
        else $error("tap counter ran past the last tap");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (m_axis_tvalid && r_state == S_IDLE))
        else $error("finished result not presented");

    a_read_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP) |-> (CW'(r_read_pos) < w_len))
        else $error("symbol read beyond buffer length");

    a_zero_stuff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_req && s_axis_tuser == pqm_pkg::KIND_TICK && r_filter && r_phase != '0)
        |=> (r_state == S_MAC && r_line_i[0] == '0 && r_line_q[0] == '0))
        else $error("stuffed tick did not enter the filter as zero");

endmodule

`default_nettype wire
